@@ rtl/tmf_pkg.sv @@
// Shared types, constants and frame-building functions of the typed message fragmenter.
`timescale 1ns / 1ps

package tmf_pkg;

    // Fixed sizes of the report and the chunk header.
    localparam logic [6:0] MAX_REPORT   = 7'd64;
    localparam logic [6:0] HEADER_BYTES = 7'd3;

    // Reset values of the configuration registers.
    localparam logic [6:0] CAP_RESET = 7'd16;
    localparam logic [7:0] TAG_RESET = 8'd0;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Report type codes that set the logical length.
    localparam logic [7:0] TYPE_TIME   = 8'hAA;
    localparam logic [7:0] TYPE_VOLUME = 8'hAB;
    localparam logic [7:0] TYPE_LAYOUT = 8'hAC;
    localparam logic [7:0] TYPE_ARTIST = 8'hAD;
    localparam logic [7:0] TYPE_TITLE  = 8'hAE;

    // Forwarding modes of the current report.
    localparam logic [1:0] MODE_WAIT  = 2'd0;
    localparam logic [1:0] MODE_WHOLE = 2'd1;
    localparam logic [1:0] MODE_CHUNK = 2'd2;
    localparam logic [1:0] MODE_DROP  = 2'd3;

    // Frame kinds on the result channel.
    localparam logic [1:0] KIND_WHOLE = 2'd0;
    localparam logic [1:0] KIND_CHUNK = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // One frame data byte, optionally preceded by a three-byte chunk header.
    typedef struct packed {
        logic       en;
        logic       hdr;
        logic [7:0] seq;
        logic [6:0] idx;
        logic [6:0] ll;
        logic [7:0] data;
        logic [1:0] kind;
        logic       is_start;
        logic       is_end;
        logic [7:0] tag;
    } t_op;

    // Work handed from the front to the back for one input transaction.
    typedef struct packed {
        t_op op0;
        t_op op1;
    } t_desc;

    // Result of forwarding one byte: the operation and the updated chunk fill.
    typedef struct packed {
        t_op        op;
        logic [7:0] fill;
    } t_send;

    // Data bytes that one chunk may carry under the given cap.
    function automatic logic [6:0] chunk_data_size(input logic [6:0] cap);
        logic [6:0] size;
        size = (cap > HEADER_BYTES) ? (cap - HEADER_BYTES) : 7'd1;
        return size;
    endfunction

    // The error result issued when a message needs chunking but the cap is too small.
    function automatic t_op error_op();
        t_op op;
        op          = '0;
        op.en       = 1'b1;
        op.kind     = KIND_ERROR;
        op.is_start = 1'b1;
        op.is_end   = 1'b1;
        return op;
    endfunction

    // Forward one report byte at position idx under the given mode.
    function automatic t_send send_op(
        input logic [1:0] mode,
        input logic [6:0] ll,
        input logic [6:0] idx,
        input logic [7:0] fill,
        input logic [6:0] cap,
        input logic [7:0] data,
        input logic [7:0] seq,
        input logic [7:0] chunk_tag,
        input logic [7:0] held_type
    );
        t_send      res;
        logic [7:0] next_fill;
        logic [7:0] idx_next;
        logic       last_byte;
        res       = '0;
        res.fill  = fill;
        idx_next  = {1'b0, idx} + 8'd1;
        last_byte = (idx_next == {1'b0, ll});
        next_fill = fill + 8'd1;
        if (idx < ll) begin
            if (mode == MODE_WHOLE) begin
                res.op.en       = 1'b1;
                res.op.data     = data;
                res.op.kind     = KIND_WHOLE;
                res.op.is_start = (idx == 7'd0);
                res.op.is_end   = last_byte;
                res.op.tag      = held_type;
            end else if (mode == MODE_CHUNK) begin
                res.op.en     = 1'b1;
                res.op.hdr    = (fill == 8'd0);
                res.op.seq    = seq;
                res.op.idx    = idx;
                res.op.ll     = ll;
                res.op.data   = data;
                res.op.kind   = KIND_CHUNK;
                res.op.is_end = (next_fill >= {1'b0, chunk_data_size(cap)}) || last_byte;
                res.op.tag    = chunk_tag;
                res.fill      = res.op.is_end ? 8'd0 : next_fill;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/typed_message_fragmenter_core.sv @@
// Top level of the typed message fragmenter: configuration port, front, queue and back.
// The block takes one report byte per transaction and turns the report into either one whole
// frame, chunk frames with a sequence, offset and total header, or an error result when the
// cap cannot hold a header. The front part accepts a byte in every cycle while its work
// queue (QUEUE_DEPTH entries) has room, even while the result register still holds an
// untaken result. The back part emits one result per cycle while the receiver does not
// stall; an input byte causes no result when dropped or a type byte, one for a whole-frame
// byte or a chunk byte inside a chunk, four when the byte opens a chunk, and up to eight when
// the length decision forwards two bytes that both open chunks. The back part's single result
// register sets the sustained rate. Registers: payload_cap at byte address 0 (reset 16),
// chunk_tag at byte address 4 (reset 0); write them only while the block is idle.
`timescale 1ns / 1ps

module typed_message_fragmenter_core #(
    parameter int QUEUE_DEPTH = tmf_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [6:0]  i_report_length,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_frame_kind,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic [7:0]  o_frame_tag,
    output logic        o_run_last
);
    import tmf_pkg::*;

    // Register indexes, taken from address bit 2.
    localparam logic REG_PAYLOAD_CAP = 1'b0;
    localparam logic REG_CHUNK_TAG   = 1'b1;

    logic [6:0] r_payload_cap;
    logic [7:0] r_chunk_tag;
    logic       cfg_write;

    logic  q_push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_desc front_desc;
    t_desc q_desc;

    // Configuration register writes.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_cap <= CAP_RESET;
            r_chunk_tag   <= TAG_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_PAYLOAD_CAP: r_payload_cap <= pwdata[6:0];
                REG_CHUNK_TAG:   r_chunk_tag   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Configuration register reads.
    always_comb begin
        unique case (paddr[2])
            REG_PAYLOAD_CAP: prdata = {25'd0, r_payload_cap};
            REG_CHUNK_TAG:   prdata = {24'd0, r_chunk_tag};
            default:         prdata = 32'd0;
        endcase
    end

    tmf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_report_length (i_report_length),
        .i_payload_cap   (r_payload_cap),
        .i_chunk_tag     (r_chunk_tag),
        .i_queue_full    (q_full),
        .o_push          (q_push),
        .o_desc          (front_desc)
    );

    tmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_desc),
        .i_pop   (q_pop)
    );

    tmf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_desc        (q_desc),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_frame_kind  (o_frame_kind),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_frame_tag   (o_frame_tag),
        .o_run_last    (o_run_last)
    );

endmodule

@@ rtl/tmf_front.sv @@
// Front part: accepts report bytes, tracks the report and classifies each byte into frame work.
`timescale 1ns / 1ps

module tmf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_data_byte,
    input  logic [6:0]    i_report_length,
    input  logic [6:0]    i_payload_cap,
    input  logic [7:0]    i_chunk_tag,
    input  logic          i_queue_full,
    output logic          o_push,
    output tmf_pkg::t_desc o_desc
);
    import tmf_pkg::*;

    // Report tracking state.
    logic [7:0] r_held_type, n_held_type;
    logic [6:0] r_pos,       n_pos;
    logic [6:0] r_ll,        n_ll;
    logic [1:0] r_mode,      n_mode;
    logic [7:0] r_fill,      n_fill;
    logic [7:0] r_cur_seq,   n_cur_seq;
    logic [7:0] r_seq_ctr,   n_seq_ctr;

    logic       accept;
    logic       empty_len;
    logic [6:0] len;
    logic       pos0;
    logic       last;
    logic       dec_go;
    logic [7:0] dec_type;
    logic [7:0] dec_b1;
    logic [8:0] b1_sum;
    logic [6:0] dec_ll;
    logic [1:0] dec_mode;
    logic [1:0] mode_use;
    logic [6:0] ll_use;
    logic [7:0] fill_start;
    logic [7:0] seq_use;
    logic [7:0] type_use;
    logic       allow_a;
    logic       allow_b;
    logic [6:0] idx_a;
    logic [7:0] byte_a;
    t_send      send_a;
    t_send      send_b;
    t_desc      desc;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    // Report length clamp and position within the report.
    assign empty_len = (i_report_length == 7'd0);
    assign len       = (i_report_length > MAX_REPORT) ? MAX_REPORT : i_report_length;
    assign pos0      = (r_pos == 7'd0);
    assign last      = (({1'b0, r_pos} + 8'd1) >= {1'b0, len});

    // The length decision comes with byte 1, or with byte 0 when it ends the report.
    assign dec_go   = pos0 ? last : (r_mode == MODE_WAIT);
    assign dec_type = pos0 ? i_data_byte : r_held_type;
    assign dec_b1   = pos0 ? 8'd0 : i_data_byte;
    assign b1_sum   = {1'b0, dec_b1} + 9'd2;

    // Logical length by report type, clamped to the report length.
    always_comb begin
        unique case (dec_type) inside
            TYPE_TIME: begin
                dec_ll = (len < 7'd3) ? len : 7'd3;
            end
            TYPE_VOLUME, TYPE_LAYOUT: begin
                dec_ll = (len < 7'd2) ? len : 7'd2;
            end
            TYPE_ARTIST, TYPE_TITLE: begin
                if (len < 7'd2 || {2'b00, len} < b1_sum) begin
                    dec_ll = len;
                end else begin
                    dec_ll = b1_sum[6:0];
                end
            end
            default: begin
                dec_ll = len;
            end
        endcase
    end

    // Whole frame, chunked, or error when the cap cannot hold a header.
    always_comb begin
        if (dec_ll <= i_payload_cap) begin
            dec_mode = MODE_WHOLE;
        end else if (i_payload_cap <= HEADER_BYTES) begin
            dec_mode = MODE_DROP;
        end else begin
            dec_mode = MODE_CHUNK;
        end
    end

    assign mode_use   = dec_go ? dec_mode : r_mode;
    assign ll_use     = dec_go ? dec_ll : r_ll;
    assign fill_start = (dec_go && dec_mode == MODE_CHUNK) ? 8'd0 : r_fill;
    assign seq_use    = (dec_go && dec_mode == MODE_CHUNK) ? r_seq_ctr : r_cur_seq;
    assign type_use   = pos0 ? i_data_byte : r_held_type;

    // First send: the held type byte at a decision, else the incoming byte.
    assign allow_a = dec_go || !pos0;
    assign allow_b = dec_go && !pos0;
    assign idx_a   = dec_go ? 7'd0 : r_pos;
    assign byte_a  = allow_b ? r_held_type : i_data_byte;

    assign send_a = send_op(mode_use, ll_use, idx_a, fill_start, i_payload_cap,
                            byte_a, seq_use, i_chunk_tag, type_use);
    assign send_b = send_op(mode_use, ll_use, r_pos, send_a.fill, i_payload_cap,
                            i_data_byte, seq_use, i_chunk_tag, type_use);

    // Assemble the work for the back part.
    always_comb begin
        desc = '0;
        if (dec_go && dec_mode == MODE_DROP) begin
            desc.op0 = error_op();
        end else begin
            if (allow_a) begin
                desc.op0 = send_a.op;
            end
            if (allow_b) begin
                desc.op1 = send_b.op;
            end
        end
    end

    assign o_desc = desc;
    assign o_push = accept && !empty_len && desc.op0.en;

    // Next state of the report tracking.
    always_comb begin
        n_held_type = r_held_type;
        n_pos       = r_pos;
        n_ll        = r_ll;
        n_mode      = r_mode;
        n_fill      = r_fill;
        n_cur_seq   = r_cur_seq;
        n_seq_ctr   = r_seq_ctr;
        if (accept) begin
            if (empty_len) begin
                n_pos  = 7'd0;
                n_mode = MODE_WAIT;
                n_fill = 8'd0;
            end else begin
                if (pos0) begin
                    n_held_type = i_data_byte;
                end
                if (dec_go) begin
                    n_ll   = dec_ll;
                    n_mode = dec_mode;
                    if (dec_mode == MODE_CHUNK) begin
                        n_cur_seq = r_seq_ctr;
                        n_seq_ctr = r_seq_ctr + 8'd1;
                    end
                end
                if (allow_b) begin
                    n_fill = send_b.fill;
                end else if (allow_a) begin
                    n_fill = send_a.fill;
                end else begin
                    n_fill = fill_start;
                end
                if (last) begin
                    n_pos  = 7'd0;
                    n_mode = MODE_WAIT;
                    n_fill = 8'd0;
                end else begin
                    n_pos = r_pos + 7'd1;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_type <= 8'd0;
            r_pos       <= 7'd0;
            r_ll        <= 7'd0;
            r_mode      <= MODE_WAIT;
            r_fill      <= 8'd0;
            r_cur_seq   <= 8'd0;
            r_seq_ctr   <= 8'd0;
        end else begin
            r_held_type <= n_held_type;
            r_pos       <= n_pos;
            r_ll        <= n_ll;
            r_mode      <= n_mode;
            r_fill      <= n_fill;
            r_cur_seq   <= n_cur_seq;
            r_seq_ctr   <= n_seq_ctr;
        end
    end

    // A report that ends leaves the tracker waiting at position zero.
    a_report_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !empty_len && last) |=> (r_pos == 7'd0 && r_mode == MODE_WAIT))
        else $error("report end did not clear the tracker");

    // The sequence counter moves only when a chunked message is decided.
    a_seq_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_ctr != n_seq_ctr) |-> (accept && dec_go && dec_mode == MODE_CHUNK))
        else $error("sequence counter advanced without a chunked message");

endmodule

@@ rtl/tmf_queue.sv @@
// Short queue of frame work between the front and the back part.
`timescale 1ns / 1ps

module tmf_queue #(
    parameter int DEPTH = tmf_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tmf_pkg::t_desc i_desc,
    output logic           o_full,
    output logic           o_valid,
    output tmf_pkg::t_desc o_desc,
    input  logic           i_pop
);
    import tmf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_entry [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

endmodule

@@ rtl/tmf_back.sv @@
// Back part: expands queued frame work into result transactions, one per unstalled cycle.
`timescale 1ns / 1ps

module tmf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tmf_pkg::t_desc i_desc,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte,
    output logic [1:0]     o_frame_kind,
    output logic           o_frame_start,
    output logic           o_frame_end,
    output logic [7:0]     o_frame_tag,
    output logic           o_run_last
);
    import tmf_pkg::*;

    // Steps within one operation: three header bytes, then the data byte.
    localparam logic [1:0] SUB_SEQ  = 2'd0;
    localparam logic [1:0] SUB_OFS  = 2'd1;
    localparam logic [1:0] SUB_TOT  = 2'd2;
    localparam logic [1:0] SUB_DATA = 2'd3;

    t_desc      r_desc;
    logic       r_busy;
    logic       r_phase;
    logic [1:0] r_sub;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [1:0] r_frame_kind;
    logic       r_frame_start;
    logic       r_frame_end;
    logic [7:0] r_frame_tag;
    logic       r_run_last;

    t_op        cur;
    logic       emit;
    logic       last_desc;
    logic       load;
    logic [7:0] n_byte;
    logic       n_start;
    logic       n_end;

    assign cur       = r_phase ? r_desc.op1 : r_desc.op0;
    assign emit      = r_busy && (!r_out_valid || !i_out_stall);
    assign last_desc = (r_sub == SUB_DATA) && (r_phase || !r_desc.op1.en);
    assign load      = (!r_busy || (emit && last_desc)) && i_valid;
    assign o_pop     = load;

    // Byte and frame markers of the current step.
    always_comb begin
        n_byte  = cur.data;
        n_start = cur.is_start;
        n_end   = cur.is_end;
        unique case (r_sub)
            SUB_SEQ: begin
                n_byte  = cur.seq;
                n_start = 1'b1;
                n_end   = 1'b0;
            end
            SUB_OFS: begin
                n_byte  = {1'b0, cur.idx};
                n_start = 1'b0;
                n_end   = 1'b0;
            end
            SUB_TOT: begin
                n_byte  = {1'b0, cur.ll};
                n_start = 1'b0;
                n_end   = 1'b0;
            end
            default: begin
                n_byte  = cur.data;
                n_start = cur.is_start;
                n_end   = cur.is_end;
            end
        endcase
    end

    // Sequencer over the operations of the current work item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_sub   <= SUB_DATA;
        end else if (load) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_sub   <= i_desc.op0.hdr ? SUB_SEQ : SUB_DATA;
        end else if (emit) begin
            if (r_sub != SUB_DATA) begin
                r_sub <= r_sub + 2'd1;
            end else if (last_desc) begin
                r_busy <= 1'b0;
            end else begin
                r_phase <= 1'b1;
                r_sub   <= r_desc.op1.hdr ? SUB_SEQ : SUB_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_desc;
        end
    end

    // Output register: filled on each step, freed when the transaction is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte    <= n_byte;
            r_frame_kind  <= cur.kind;
            r_frame_start <= n_start;
            r_frame_end   <= n_end;
            r_frame_tag   <= cur.tag;
            r_run_last    <= last_desc;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_frame_kind  = r_frame_kind;
    assign o_frame_start = r_frame_start;
    assign o_frame_end   = r_frame_end;
    assign o_frame_tag   = r_frame_tag;
    assign o_run_last    = r_run_last;

    // Header steps only occur for operations that open a chunk.
    a_header_only_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_sub != SUB_DATA) |-> (cur.hdr && cur.kind == KIND_CHUNK))
        else $error("header step on an operation without a header");

    // An error result is a frame of its own and the only result of its transaction.
    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_frame_kind == KIND_ERROR)
            |-> (r_frame_start && r_frame_end && r_run_last))
        else $error("malformed error result");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the typed message fragmenter core.
`timescale 1ns / 1ps

module tb_top;
    import tmf_pkg::*;

    localparam int          CLK_PERIOD  = 12;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          SETTLE      = 40;
    localparam logic [2:0]  ADDR_CAP    = 3'd0;
    localparam logic [2:0]  ADDR_TAG    = 3'd4;

    // One frame byte as seen on the result channel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       start;
        logic       fin;
        logic [7:0] tag;
        logic       run_last;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic [6:0]  i_report_length = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_frame_kind;
    logic        o_frame_start;
    logic        o_frame_end;
    logic [7:0]  o_frame_tag;
    logic        o_run_last;

    // Predictor state and configuration mirror.
    logic [6:0]  cap_setting = CAP_RESET;
    logic [7:0]  tag_setting = TAG_RESET;
    logic [7:0]  type_held = '0;
    logic [6:0]  report_pos = '0;
    logic [7:0]  msg_length = '0;
    logic [1:0]  route_mode = MODE_WAIT;
    logic [7:0]  chunk_used = '0;
    logic [7:0]  chunk_seq = '0;
    logic [7:0]  next_seq = '0;

    t_frame_byte step_frames[$];
    t_frame_byte frames_due[$];

    int  failures = 0;
    int  bytes_sent = 0;
    int  frames_checked = 0;
    int  chunk_bytes_seen = 0;
    int  error_results_seen = 0;
    int  cycle_count = 0;
    int  hold_request = 0;
    bit  in_gaps_on = 1'b1;
    bit  out_gaps_on = 1'b1;

    typed_message_fragmenter_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_report_length(i_report_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_frame_kind   (o_frame_kind),
        .o_frame_start  (o_frame_start),
        .o_frame_end    (o_frame_end),
        .o_frame_tag    (o_frame_tag),
        .o_run_last     (o_run_last)
    );

    // Clock generation.
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Append one predicted frame byte for the current input byte.
    function automatic void emit(input logic [7:0] b, input logic [1:0] k, input logic s,
                                 input logic e, input logic [7:0] t);
        t_frame_byte f;
        f.out_byte = b;
        f.kind     = k;
        f.start    = s;
        f.fin      = e;
        f.tag      = t;
        f.run_last = 1'b0;
        step_frames.push_back(f);
    endfunction

    // Fix the logical length and choose whole, chunked or error handling.
    function automatic void decide_route(input logic [7:0] typ, input logic [7:0] b1,
                                         input int len);
        int ll;
        if (typ == TYPE_TIME) begin
            ll = (len < 3) ? len : 3;
        end else if (typ == TYPE_VOLUME || typ == TYPE_LAYOUT) begin
            ll = (len < 2) ? len : 2;
        end else if (typ == TYPE_ARTIST || typ == TYPE_TITLE) begin
            ll = (len < 2) ? len : ((len < int'(b1) + 2) ? len : int'(b1) + 2);
        end else begin
            ll = len;
        end
        msg_length = 8'(ll);
        if (ll <= int'(cap_setting)) begin
            route_mode = MODE_WHOLE;
        end else if (cap_setting <= HEADER_BYTES) begin
            route_mode = MODE_DROP;
            emit(8'd0, KIND_ERROR, 1'b1, 1'b1, 8'd0);
        end else begin
            route_mode = MODE_CHUNK;
            chunk_used = '0;
            chunk_seq  = next_seq;
            next_seq   = next_seq + 8'd1;
        end
    endfunction

    // Predict the frame bytes for one report byte at offset idx.
    function automatic void forward_byte(input int idx, input logic [7:0] b);
        int data_size;
        bit done;
        if (idx >= int'(msg_length)) return;
        if (route_mode == MODE_WHOLE) begin
            emit(b, KIND_WHOLE, idx == 0, idx + 1 == int'(msg_length), type_held);
        end else if (route_mode == MODE_CHUNK) begin
            data_size = (cap_setting > HEADER_BYTES) ? int'(cap_setting - HEADER_BYTES) : 1;
            if (chunk_used == 8'd0) begin
                emit(chunk_seq, KIND_CHUNK, 1'b1, 1'b0, tag_setting);
                emit(8'(idx), KIND_CHUNK, 1'b0, 1'b0, tag_setting);
                emit(msg_length, KIND_CHUNK, 1'b0, 1'b0, tag_setting);
            end
            chunk_used = chunk_used + 8'd1;
            done = (int'(chunk_used) >= data_size) || (idx + 1 == int'(msg_length));
            emit(b, KIND_CHUNK, 1'b0, done, tag_setting);
            if (done) chunk_used = '0;
        end
    endfunction

    // Advance the predictor by one accepted report byte.
    function automatic void predict_frames(input logic [7:0] b, input logic [6:0] rl);
        int len;
        int pos;
        bit last;
        t_frame_byte f;
        step_frames.delete();
        if (rl == 7'd0) begin
            report_pos = '0;
            route_mode = MODE_WAIT;
            chunk_used = '0;
            return;
        end
        len  = (rl > MAX_REPORT) ? int'(MAX_REPORT) : int'(rl);
        pos  = int'(report_pos);
        last = (pos + 1 >= len);
        if (pos == 0) begin
            type_held = b;
            if (last) begin
                decide_route(b, 8'd0, len);
                forward_byte(0, b);
            end
        end else if (route_mode == MODE_WAIT) begin
            decide_route(type_held, b, len);
            forward_byte(0, type_held);
            forward_byte(pos, b);
        end else begin
            forward_byte(pos, b);
        end
        if (last) begin
            report_pos = '0;
            route_mode = MODE_WAIT;
            chunk_used = '0;
        end else begin
            report_pos = 7'(pos + 1);
        end
        if (step_frames.size() > 0) begin
            f = step_frames.pop_back();
            f.run_last = 1'b1;
            step_frames.push_back(f);
        end
        foreach (step_frames[i]) frames_due.push_back(step_frames[i]);
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            frames_checked++;
            if (o_frame_kind == KIND_CHUNK) chunk_bytes_seen++;
            if (o_frame_kind == KIND_ERROR) error_results_seen++;
            if (frames_due.size() == 0) begin
                $error("unexpected frame byte %0h with no prediction pending", o_out_byte);
                failures++;
            end else begin
                want = frames_due.pop_front();
                if (o_out_byte != want.out_byte) begin
                    $error("out_byte expected %0h actual %0h", want.out_byte, o_out_byte);
                    failures++;
                end
                if (o_frame_kind != want.kind) begin
                    $error("frame_kind expected %0d actual %0d", want.kind, o_frame_kind);
                    failures++;
                end
                if (o_frame_start != want.start) begin
                    $error("frame_start expected %0b actual %0b", want.start, o_frame_start);
                    failures++;
                end
                if (o_frame_end != want.fin) begin
                    $error("frame_end expected %0b actual %0b", want.fin, o_frame_end);
                    failures++;
                end
                if (o_frame_tag != want.tag) begin
                    $error("frame_tag expected %0h actual %0h", want.tag, o_frame_tag);
                    failures++;
                end
                if (o_run_last != want.run_last) begin
                    $error("run_last expected %0b actual %0b", want.run_last, o_run_last);
                    failures++;
                end
            end
        end
    end

    // Receiver stall generator; a long hold-off takes priority over the short random bursts.
    always @(posedge i_clk) begin
        int hold_left;
        int stall_left;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_request > 0) begin
            hold_left = hold_request - 1;
            hold_request = 0;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (out_gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Offer one report byte and wait until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic [6:0] rl);
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_report_length <= rl;
        do @(posedge i_clk); while (o_in_stall);
        predict_frames(b, rl);
        bytes_sent++;
    endtask

    // Send a report of count bytes: the type, the second byte, then random content.
    task automatic send_report(input logic [7:0] typ, input logic [7:0] second,
                               input int count, input logic [6:0] rl);
        for (int i = 0; i < count; i++) begin
            if (i == 0) send_byte(typ, rl);
            else if (i == 1) send_byte(second, rl);
            else send_byte(8'($urandom_range(0, 255)), rl);
        end
    endtask

    // Stop offering, let every predicted frame byte drain, then let the block settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write one register through the configuration port and read it back.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] expected;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_CAP) begin
            cap_setting = value[6:0];
            expected = {25'd0, value[6:0]};
        end else begin
            tag_setting = value[7:0];
            expected = {24'd0, value[7:0]};
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata != expected) begin
            $error("prdata expected %0h actual %0h", expected, prdata);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [6:0] cap, input logic [7:0] tag);
        wait_idle();
        write_register(ADDR_CAP, {25'd0, cap});
        write_register(ADDR_TAG, {24'd0, tag});
    endtask

    // Every report type under the reset cap, including dropped trailing bytes.
    task automatic test_message_types();
        send_report(TYPE_TIME, 8'h05, 4, 7'd4);
        send_report(TYPE_VOLUME, 8'h00, 1, 7'd1);
        send_report(TYPE_LAYOUT, 8'h7F, 2, 7'd2);
        send_report(TYPE_ARTIST, 8'h00, 4, 7'd4);
        send_report(TYPE_TITLE, 8'hFF, 3, 7'd3);
        send_report(8'hFF, 8'h00, 2, 7'd2);
    endtask

    // A message longer than the cap split into two-byte chunks.
    task automatic test_chunk_frames();
        configure(7'd5, 8'hFF);
        send_report(8'h00, 8'hFF, 6, 7'd6);
    endtask

    // Chunking needed but no room for the header: one error result per report.
    task automatic test_cap_too_small();
        configure(7'd1, 8'h3C);
        send_report(8'h7E, 8'h01, 2, 7'd2);
        configure(7'd0, 8'h00);
        send_report(TYPE_VOLUME, 8'h00, 1, 7'd1);
    endtask

    // Empty, oversize and changing report lengths.
    task automatic test_report_lengths();
        configure(7'd16, 8'h00);
        send_byte(8'h42, 7'd5);
        send_byte(8'h99, 7'd0);
        send_byte(TYPE_TIME, 7'd127);
        send_byte(8'h11, 7'd127);
        send_byte(8'h22, 7'd0);
        // The length drops under the position, so the open frame is never ended.
        send_report(8'h20, 8'h01, 3, 7'd10);
        send_byte(8'h03, 7'd3);
    endtask

    // The cap moves between chunks of one message.
    task automatic test_cap_change_mid_message();
        configure(7'd5, 8'hA5);
        send_byte(8'h40, 7'd6);
        send_byte(8'h01, 7'd6);
        configure(7'd2, 8'hA5);
        send_byte(8'h02, 7'd6);
        send_byte(8'h03, 7'd6);
        configure(7'd64, 8'hA5);
        send_byte(8'h04, 7'd6);
        send_byte(8'h05, 7'd6);
    endtask

    // The receiver holds off while bytes keep coming, then the sender waits for a drain.
    task automatic test_output_backpressure();
        configure(7'd8, 8'h5A);
        in_gaps_on = 1'b0;
        hold_request = 300;
        for (int r = 0; r < 3; r++) send_report(8'h55, 8'h00, 12, 7'd12);
        wait_idle();
        in_gaps_on = 1'b1;
    endtask

    // One random report: mostly well formed, sometimes noise closed by an empty byte.
    task automatic random_report();
        logic [7:0] typ;
        logic [7:0] b1;
        int         sel;
        int         rl;
        int         len;
        int         count;
        logic [6:0] noisy_rl;
        sel = $urandom_range(0, 6);
        case (sel)
            0: typ = TYPE_TIME;
            1: typ = TYPE_VOLUME;
            2: typ = TYPE_LAYOUT;
            3: typ = TYPE_ARTIST;
            4: typ = TYPE_TITLE;
            default: typ = 8'($urandom_range(0, 255));
        endcase
        sel = $urandom_range(0, 19);
        if (sel < 14) rl = $urandom_range(1, 12);
        else if (sel < 18) rl = $urandom_range(13, 64);
        else rl = $urandom_range(65, 127);
        len = (rl > 64) ? 64 : rl;
        b1 = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 12));
        if ($urandom_range(0, 9) < 8) begin
            send_report(typ, b1, len, 7'(rl));
        end else begin
            count = $urandom_range(1, len);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 9) == 0) noisy_rl = 7'd0;
                else if ($urandom_range(0, 3) == 0) noisy_rl = 7'($urandom_range(1, 127));
                else noisy_rl = 7'(rl);
                send_byte((i == 0) ? typ : 8'($urandom_range(0, 255)), noisy_rl);
            end
            send_byte(8'($urandom_range(0, 255)), 7'd0);
        end
    endtask

    // Random traffic in phases, each under its own cap and tag.
    task automatic test_random_traffic();
        int         first;
        int         phase_mark;
        logic [6:0] cap;
        first = bytes_sent;
        phase_mark = first;
        while (bytes_sent < first + 220) begin
            if (bytes_sent >= phase_mark && bytes_sent < first + 170) begin
                case ($urandom_range(0, 5))
                    0: cap = 7'd0;
                    1: cap = 7'd3;
                    2: cap = 7'd4;
                    3: cap = 7'd64;
                    default: cap = 7'($urandom_range(0, 64));
                endcase
                configure(cap, ($urandom_range(0, 2) == 0) ? 8'hFF
                                                            : 8'($urandom_range(0, 255)));
                in_gaps_on  = ($urandom_range(0, 2) != 0);
                out_gaps_on = ($urandom_range(0, 2) != 0);
                phase_mark += 45;
            end
            // The final stretch runs at full rate on both sides.
            if (bytes_sent >= first + 170) begin
                in_gaps_on  = 1'b0;
                out_gaps_on = 1'b0;
            end
            random_report();
        end
    endtask

    // Test sequence.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_message_types();
        test_chunk_frames();
        test_cap_too_small();
        test_report_lengths();
        test_cap_change_mid_message();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();
        $display("Sent %0d report bytes; checked %0d frame bytes (%0d chunk, %0d error).",
                 bytes_sent, frames_checked, chunk_bytes_seen, error_results_seen);
        $display("Covered all report types, chunking, cap changes, length edge cases.");
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
